/* rtl/fpp_pkg.sv */
// Shared widths, constants and the CRC byte function for the framed packet parser.
// No dependencies; used by the top level, its port checker and the bench.
`default_nettype none

package fpp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SEQ_W       = 16;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned CRC_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 40;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  localparam logic [CRC_W-1:0]  CRC_POLY       = 16'h1021;
  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] VERSION_RST    = 8'h01;
  localparam logic [CRC_W-1:0]  CRC_INIT_RST   = 16'hFFFF;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT   = 2'd2;

  // Result beat layout in tdata, lowest bit first
  localparam int unsigned OUT_TYPE_LSB = 0;
  localparam int unsigned OUT_SEQ_LSB  = OUT_TYPE_LSB + BYTE_W;
  localparam int unsigned OUT_LEN_LSB  = OUT_SEQ_LSB + SEQ_W;
  localparam int unsigned OUT_PAY_LSB  = OUT_LEN_LSB + LEN_W;
  localparam int unsigned OUT_USED_W   = OUT_PAY_LSB + BYTE_W;

  // CRC-16, MSB first, one byte
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      else            c = {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/framed_packet_parser_crc16.sv */
// Header, payload and CRC bytes are taken one per cycle, the high CRC byte only
// once the output register is free; the result of an empty frame is loaded the
// cycle after its last CRC byte. A good frame with payload is read out of the
// payload memory beat by beat (read issue, then output load once the output is
// free); no input is taken during read-out. Reset is asynchronous active low:
// state, config and out valid clear; output data and payload memory do not.
`default_nettype none

module framed_packet_parser_crc16 #(
  parameter int unsigned MAX_PAYLOAD = fpp_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // rx byte stream; tdata: rx_byte[7:0]
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  input  wire logic [fpp_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
  // frame beats; tdata: frame_type[7:0], frame_seq[23:8], frame_length[30:24],
  // payload_byte[38:31], zero[39]
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output      logic [fpp_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
  // tuser: has_byte[0]
  output      logic                                m_axis_tuser,
  output      logic                                m_axis_tlast,
  input  wire logic                                cfg_we_i,
  input  wire logic [fpp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [fpp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [3:0] {
    PH_HUNT, PH_VERSION, PH_TYPE, PH_SEQLO, PH_SEQHI, PH_LENLO, PH_LENHI,
    PH_PAYLOAD, PH_CRCLO, PH_CRCHI, PH_EMIT_RD, PH_EMIT_WR
  } phase_e;

  // configuration
  logic [fpp_pkg::BYTE_W-1:0] start_q, ver_q;
  logic [fpp_pkg::CRC_W-1:0]  crc_init_q;

  phase_e                     phase_q, phase_d;
  logic [fpp_pkg::BYTE_W-1:0] type_q, type_d;
  logic [fpp_pkg::SEQ_W-1:0]  seq_q, seq_d;
  logic [fpp_pkg::BYTE_W-1:0] len_lo_q, len_lo_d;
  logic [fpp_pkg::LEN_W-1:0]  len_q, len_d;
  logic [fpp_pkg::LEN_W-1:0]  cnt_q, cnt_d;
  logic [fpp_pkg::BYTE_W-1:0] crc_lo_q, crc_lo_d;
  logic [fpp_pkg::CRC_W-1:0]  crc_q, crc_d;

  logic                       out_valid_q, out_valid_d;
  logic [fpp_pkg::BYTE_W-1:0] out_pay_q, out_pay_d;
  logic [fpp_pkg::LEN_W-1:0]  out_len_q, out_len_d;
  logic [fpp_pkg::BYTE_W-1:0] out_type_q, out_type_d;
  logic [fpp_pkg::SEQ_W-1:0]  out_seq_q, out_seq_d;
  logic                       out_has_q, out_has_d;
  logic                       out_last_q, out_last_d;

  logic [fpp_pkg::BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [fpp_pkg::BYTE_W-1:0] rd_data_q;

  logic                       in_acc, out_free, mem_we;
  logic [fpp_pkg::BYTE_W-1:0] rx_b;
  logic [fpp_pkg::SEQ_W-1:0]  len_full;
  logic [fpp_pkg::LEN_W-1:0]  cnt_inc;
  logic [fpp_pkg::CRC_W-1:0]  crc_next;

  assign rx_b     = s_axis_tdata;
  assign out_free = !out_valid_q || m_axis_tready;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign len_full = {rx_b, len_lo_q};
  assign cnt_inc  = cnt_q + 1'b1;
  assign crc_next = fpp_pkg::crc_feed(crc_q, rx_b);
  assign mem_we   = in_acc && (phase_q == PH_PAYLOAD);

  // CRC high byte may produce a beat directly, so it waits for a free slot
  always_comb begin
    case (phase_q)
      PH_EMIT_RD, PH_EMIT_WR: s_axis_tready = 1'b0;
      PH_CRCHI:               s_axis_tready = out_free;
      default:                s_axis_tready = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= fpp_pkg::START_BYTE_RST;
      ver_q      <= fpp_pkg::VERSION_RST;
      crc_init_q <= fpp_pkg::CRC_INIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fpp_pkg::CFG_START_BYTE: start_q    <= cfg_data_i[fpp_pkg::BYTE_W-1:0];
        fpp_pkg::CFG_VERSION:    ver_q      <= cfg_data_i[fpp_pkg::BYTE_W-1:0];
        fpp_pkg::CFG_CRC_INIT:   crc_init_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    seq_d       = seq_q;
    len_lo_d    = len_lo_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    crc_lo_d    = crc_lo_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_pay_d   = out_pay_q;
    out_len_d   = out_len_q;
    out_type_d  = out_type_q;
    out_seq_d   = out_seq_q;
    out_has_d   = out_has_q;
    out_last_d  = out_last_q;

    case (phase_q)
      PH_VERSION: if (in_acc) begin
        if (rx_b == ver_q) begin
          crc_d   = crc_next;
          phase_d = PH_TYPE;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_TYPE: if (in_acc) begin
        type_d  = rx_b;
        crc_d   = crc_next;
        phase_d = PH_SEQLO;
      end
      PH_SEQLO: if (in_acc) begin
        seq_d   = {8'h00, rx_b};
        crc_d   = crc_next;
        phase_d = PH_SEQHI;
      end
      PH_SEQHI: if (in_acc) begin
        seq_d   = {rx_b, seq_q[7:0]};
        crc_d   = crc_next;
        phase_d = PH_LENLO;
      end
      PH_LENLO: if (in_acc) begin
        len_lo_d = rx_b;
        crc_d    = crc_next;
        phase_d  = PH_LENHI;
      end
      PH_LENHI: if (in_acc) begin
        crc_d = crc_next;
        if (len_full > fpp_pkg::SEQ_W'(MAX_PAYLOAD)) begin
          phase_d = PH_HUNT;
        end else begin
          len_d   = len_full[fpp_pkg::LEN_W-1:0];
          phase_d = (len_full == '0) ? PH_CRCLO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: if (in_acc) begin
        cnt_d = cnt_inc;
        crc_d = crc_next;
        if (cnt_inc >= len_q) phase_d = PH_CRCLO;
      end
      PH_CRCLO: if (in_acc) begin
        crc_lo_d = rx_b;
        phase_d  = PH_CRCHI;
      end
      PH_CRCHI: if (in_acc) begin
        phase_d = PH_HUNT;
        if ({rx_b, crc_lo_q} == crc_q) begin
          if (len_q == '0) begin
            out_valid_d = 1'b1;
            out_type_d  = type_q;
            out_seq_d   = seq_q;
            out_len_d   = '0;
            out_pay_d   = '0;
            out_has_d   = 1'b0;
            out_last_d  = 1'b1;
          end else begin
            cnt_d   = '0;
            phase_d = PH_EMIT_RD;
          end
        end
      end
      PH_EMIT_RD: phase_d = PH_EMIT_WR;
      PH_EMIT_WR: if (out_free) begin
        out_valid_d = 1'b1;
        out_type_d  = type_q;
        out_seq_d   = seq_q;
        out_len_d   = len_q;
        out_pay_d   = rd_data_q;
        out_has_d   = 1'b1;
        out_last_d  = (cnt_inc == len_q);
        cnt_d       = cnt_inc;
        phase_d     = (cnt_inc == len_q) ? PH_HUNT : PH_EMIT_RD;
      end
      default: if (in_acc) begin
        // hunting; unused codes behave the same
        if (rx_b == start_q) begin
          cnt_d   = '0;
          crc_d   = crc_init_q;
          phase_d = PH_VERSION;
        end else begin
          phase_d = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      type_q      <= '0;
      seq_q       <= '0;
      len_lo_q    <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      crc_lo_q    <= '0;
      crc_q       <= fpp_pkg::CRC_INIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      type_q      <= type_d;
      seq_q       <= seq_d;
      len_lo_q    <= len_lo_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      crc_lo_q    <= crc_lo_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register, no reset needed
  always_ff @(posedge clk_i) begin
    out_pay_q  <= out_pay_d;
    out_len_q  <= out_len_d;
    out_type_q <= out_type_d;
    out_seq_q  <= out_seq_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
  end

  // payload memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[cnt_q[AW-1:0]] <= rx_b;
    if (phase_q == PH_EMIT_RD) rd_data_q <= mem[cnt_q[AW-1:0]];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(fpp_pkg::TDATA_OUT_W - fpp_pkg::OUT_USED_W){1'b0}},
                          out_pay_q, out_len_q, out_seq_q, out_type_q};
  assign m_axis_tuser  = out_has_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

/* rtl/fpp_checker.sv */
// Port-level checks for the framed packet parser, bound to the top level.
// Depends on fpp_pkg for widths and the result beat layout.
`default_nettype none

module fpp_checker #(
  parameter int unsigned MAX_PAYLOAD = fpp_pkg::MAX_PAYLOAD_DEF
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [fpp_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input wire logic                            m_axis_tuser,
  input wire logic                            m_axis_tlast
);

  logic [fpp_pkg::LEN_W-1:0]  len_f;
  logic [fpp_pkg::BYTE_W-1:0] pay_f;

  assign len_f = m_axis_tdata[fpp_pkg::OUT_LEN_LSB +: fpp_pkg::LEN_W];
  assign pay_f = m_axis_tdata[fpp_pkg::OUT_PAY_LSB +: fpp_pkg::BYTE_W];

  // a pending beat is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // an empty frame is a single beat of zero length and zero data
  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && len_f == '0 && pay_f == '0)
    else $error("malformed empty-frame beat");

  // payload beats carry a length within range
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      len_f != '0 && len_f <= fpp_pkg::LEN_W'(MAX_PAYLOAD))
    else $error("frame length out of range");

  // within a run the header fields stay the same from beat to beat
  a_run_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
      m_axis_tdata[fpp_pkg::OUT_PAY_LSB-1:0] ==
      $past(m_axis_tdata[fpp_pkg::OUT_PAY_LSB-1:0]))
    else $error("header changed inside a frame run");

endmodule

bind framed_packet_parser_crc16 fpp_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_fpp_checker (.*);

`default_nettype wire

/* bench/framed_packet_parser_crc16_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for framed_packet_parser_crc16: directed and random byte
// streams of good, broken and noisy frames, every frame beat checked against a
// behavioral parser kept in the bench. Needs fpp_pkg and the RTL top only.

module framed_packet_parser_crc16_tb;

  localparam int unsigned PAY_MAX      = fpp_pkg::MAX_PAYLOAD_DEF;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned IDLE_PCT     = 28;
  localparam int unsigned PHASE_ITEMS  = 80;
  localparam int unsigned DIR_ROWS     = 28;
  localparam logic [fpp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    P_HUNT, P_VER, P_TYPE, P_SEQLO, P_SEQHI, P_LENLO, P_LENHI, P_PAY, P_CRCLO, P_CRCHI
  } parse_phase_e;

  // directed rows: a literal byte, or the FCS bytes taken from the running CRC
  typedef enum logic [1:0] {TOK_BYTE, TOK_CRC_LO, TOK_CRC_HI} row_kind_e;

  typedef struct packed {
    logic [7:0]  ftype;
    logic [15:0] fseq;
    logic [6:0]  flen;
    logic [7:0]  fbyte;
    logic        has;
    logic        is_last;
  } frame_beat_t;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  val;
    logic        typed;
    frame_beat_t want;
  } dir_row_t;

  localparam frame_beat_t NO_BEAT = '0;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [fpp_pkg::TDATA_IN_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [fpp_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            cfg_we_i = 1'b0;
  logic [fpp_pkg::CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [fpp_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;

  // parser model state and its copy of the registers
  parse_phase_e ph = P_HUNT;
  logic [7:0]   p_type = '0;
  logic [15:0]  p_seq = '0;
  logic [15:0]  p_len = '0;
  logic [7:0]   p_mem [PAY_MAX];
  logic [6:0]   p_cnt = '0;
  logic [7:0]   p_crc_lo = '0;
  logic [15:0]  p_crc = fpp_pkg::CRC_INIT_RST;
  logic [7:0]   c_sof = fpp_pkg::START_BYTE_RST;
  logic [7:0]   c_ver = fpp_pkg::VERSION_RST;
  logic [15:0]  c_init = fpp_pkg::CRC_INIT_RST;

  frame_beat_t frame_beats_q [$];
  int          mismatch_cnt = 0;
  int          rx_count = 0;
  int          last_emit = 0;
  bit          calm = 1'b0;
  int unsigned stall_cycles = 0;

  framed_packet_parser_crc16 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // bitwise form: feedback is the CRC msb xor the next data bit
  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) r = r ^ fpp_pkg::CRC_POLY;
    end
    return r;
  endfunction

  task automatic clear_frame();
    ph = P_HUNT;
    p_type = '0;
    p_seq = '0;
    p_len = '0;
    p_cnt = '0;
    p_crc_lo = '0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    last_emit = 0;
    case (ph)
      P_VER: begin
        if (b == c_ver) begin
          p_crc = crc16_next(p_crc, b);
          ph = P_TYPE;
        end else begin
          ph = P_HUNT;
        end
      end
      P_TYPE: begin
        p_type = b;
        p_crc = crc16_next(p_crc, b);
        ph = P_SEQLO;
      end
      P_SEQLO: begin
        p_seq = {8'h00, b};
        p_crc = crc16_next(p_crc, b);
        ph = P_SEQHI;
      end
      P_SEQHI: begin
        p_seq[15:8] = b;
        p_crc = crc16_next(p_crc, b);
        ph = P_LENLO;
      end
      P_LENLO: begin
        p_len = {8'h00, b};
        p_crc = crc16_next(p_crc, b);
        ph = P_LENHI;
      end
      P_LENHI: begin
        p_len[15:8] = b;
        p_crc = crc16_next(p_crc, b);
        if (p_len > PAY_MAX) clear_frame();
        else if (p_len == 0) ph = P_CRCLO;
        else ph = P_PAY;
      end
      P_PAY: begin
        if (p_cnt < PAY_MAX) p_mem[p_cnt] = b;
        p_cnt = p_cnt + 7'd1;
        p_crc = crc16_next(p_crc, b);
        if (p_cnt >= p_len) ph = P_CRCLO;
      end
      P_CRCLO: begin
        p_crc_lo = b;
        ph = P_CRCHI;
      end
      P_CRCHI: begin
        if ({b, p_crc_lo} == p_crc) begin
          if (p_len == 0) begin
            frame_beats_q.push_back('{p_type, p_seq, 7'd0, 8'h00, 1'b0, 1'b1});
            last_emit = 1;
          end else begin
            for (int k = 0; k < p_len && k < PAY_MAX; k++) begin
              frame_beats_q.push_back('{p_type, p_seq, p_len[6:0], p_mem[k], 1'b1,
                                        (k + 1 == p_len)});
              last_emit++;
            end
          end
        end
        clear_frame();
      end
      default: begin
        if (b == c_sof) begin
          clear_frame();
          p_crc = c_init;
          ph = P_VER;
        end else begin
          ph = P_HUNT;
        end
      end
    endcase
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("%0t ERROR %s: got %0h, want %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // once a beat is offered it stays offered until taken
  task automatic push_byte(input logic [7:0] b);
    bit taken;
    bit shown;
    taken = 1'b0;
    shown = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      if (!shown && !calm && $urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        shown = 1'b1;
      end
      @(posedge clk_i);
      taken = s_axis_tvalid && s_axis_tready;
    end
    rx_count++;
    parse_rx_byte(b);
  endtask

  // stop sending, let every expected beat drain, then idle for the DRAIN_CYCLES margin
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (frame_beats_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [fpp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fpp_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      fpp_pkg::CFG_START_BYTE: c_sof = val[7:0];
      fpp_pkg::CFG_VERSION:    c_ver = val[7:0];
      fpp_pkg::CFG_CRC_INIT:   c_init = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // payload and FCS are only sent when the length is legal
  task automatic send_frame(input logic [7:0] typ, input logic [15:0] seq,
                            input logic [15:0] len, input bit bad_crc);
    logic [15:0] fcs;
    push_byte(c_sof);
    push_byte(c_ver);
    push_byte(typ);
    push_byte(seq[7:0]);
    push_byte(seq[15:8]);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    if (len <= PAY_MAX) begin
      repeat (len) push_byte(8'($urandom_range(0, 255)));
      fcs = p_crc;
      if (bad_crc) fcs = fcs ^ 16'($urandom_range(1, 65535));
      push_byte(fcs[7:0]);
      push_byte(fcs[15:8]);
    end
  endtask

  task automatic run_phase(input int n_items, input bit with_max);
    int          stop_at;
    int unsigned pick;
    int unsigned len_pick;
    logic [15:0] len;
    stop_at = rx_count + n_items;
    if (with_max)
      send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 16'(PAY_MAX), 1'b0);
    while (rx_count < stop_at) begin
      pick = $urandom_range(0, 99);
      len_pick = $urandom_range(0, 19);
      if (len_pick == 0) len = '0;
      else if (len_pick == 1) len = 16'($urandom_range(9, PAY_MAX - 1));
      else len = 16'($urandom_range(1, 8));
      if (pick < 8) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
        push_byte(c_sof);
        push_byte(c_ver ^ 8'($urandom_range(1, 255)));
      end else if (pick < 22) begin
        if ($urandom_range(0, 1)) len = 16'($urandom_range(PAY_MAX + 1, 255));
        else len = 16'($urandom_range(256, 65535));
        send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), len, 1'b0);
      end else begin
        send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), len,
                   pick < 30);
      end
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    frame_beat_t got;
    frame_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ftype   = m_axis_tdata[fpp_pkg::OUT_TYPE_LSB +: fpp_pkg::BYTE_W];
      got.fseq    = m_axis_tdata[fpp_pkg::OUT_SEQ_LSB +: fpp_pkg::SEQ_W];
      got.flen    = m_axis_tdata[fpp_pkg::OUT_LEN_LSB +: fpp_pkg::LEN_W];
      got.fbyte   = m_axis_tdata[fpp_pkg::OUT_PAY_LSB +: fpp_pkg::BYTE_W];
      got.has     = m_axis_tuser;
      got.is_last = m_axis_tlast;
      if (frame_beats_q.size() == 0) begin
        report("beat with nothing expected", 16'(got.fbyte), 16'h0);
      end else begin
        want = frame_beats_q.pop_front();
        if (got.ftype !== want.ftype) report("frame_type", 16'(got.ftype), 16'(want.ftype));
        if (got.fseq !== want.fseq) report("frame_seq", got.fseq, want.fseq);
        if (got.flen !== want.flen) report("frame_length", 16'(got.flen), 16'(want.flen));
        if (got.fbyte !== want.fbyte) report("payload_byte", 16'(got.fbyte), 16'(want.fbyte));
        if (got.has !== want.has) report("has_byte", 16'(got.has), 16'(want.has));
        if (got.is_last !== want.is_last) report("tlast", 16'(got.is_last), 16'(want.is_last));
      end
    end
  end

  // counts cycles in which no beat and no register write moves
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    dir_row_t   dir_tab [DIR_ROWS];
    logic [7:0] rx_b;

    dir_tab = '{
      // wrong version right after the start byte
      '{TOK_BYTE, 8'hAA, 1'b0, NO_BEAT}, '{TOK_BYTE, 8'h00, 1'b0, NO_BEAT},
      // empty frame, all-zero header
      '{TOK_BYTE, 8'hAA, 1'b0, NO_BEAT}, '{TOK_BYTE, 8'h01, 1'b0, NO_BEAT},
      '{TOK_BYTE, 8'h00, 1'b0, NO_BEAT}, '{TOK_BYTE, 8'h00, 1'b0, NO_BEAT},
      '{TOK_BYTE, 8'h00, 1'b0, NO_BEAT}, '{TOK_BYTE, 8'h00, 1'b0, NO_BEAT},
      '{TOK_BYTE, 8'h00, 1'b0, NO_BEAT}, '{TOK_CRC_LO, 8'h00, 1'b0, NO_BEAT},
      '{TOK_CRC_HI, 8'h00, 1'b1, '{8'h00, 16'h0000, 7'd0, 8'h00, 1'b0, 1'b1}},
      // one payload byte, all-ones type, sequence and payload
      '{TOK_BYTE, 8'hAA, 1'b0, NO_BEAT}, '{TOK_BYTE, 8'h01, 1'b0, NO_BEAT},
      '{TOK_BYTE, 8'hFF, 1'b0, NO_BEAT}, '{TOK_BYTE, 8'hFF, 1'b0, NO_BEAT},
      '{TOK_BYTE, 8'hFF, 1'b0, NO_BEAT}, '{TOK_BYTE, 8'h01, 1'b0, NO_BEAT},
      '{TOK_BYTE, 8'h00, 1'b0, NO_BEAT}, '{TOK_BYTE, 8'hFF, 1'b0, NO_BEAT},
      '{TOK_CRC_LO, 8'h00, 1'b0, NO_BEAT},
      '{TOK_CRC_HI, 8'h00, 1'b1, '{8'hFF, 16'hFFFF, 7'd1, 8'hFF, 1'b1, 1'b1}},
      // length one above the limit, frame dropped
      '{TOK_BYTE, 8'hAA, 1'b0, NO_BEAT}, '{TOK_BYTE, 8'h01, 1'b0, NO_BEAT},
      '{TOK_BYTE, 8'h00, 1'b0, NO_BEAT}, '{TOK_BYTE, 8'h00, 1'b0, NO_BEAT},
      '{TOK_BYTE, 8'h00, 1'b0, NO_BEAT}, '{TOK_BYTE, 8'h41, 1'b0, NO_BEAT},
      '{TOK_BYTE, 8'h00, 1'b0, NO_BEAT}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      case (dir_tab[r].kind)
        TOK_CRC_LO: rx_b = p_crc[7:0];
        TOK_CRC_HI: rx_b = p_crc[15:8];
        default:    rx_b = dir_tab[r].val;
      endcase
      push_byte(rx_b);
      if (dir_tab[r].typed) begin
        repeat (last_emit) void'(frame_beats_q.pop_back());
        frame_beats_q.push_back(dir_tab[r].want);
      end
    end

    // registers change in the middle of a header; the open frame keeps its CRC seed
    push_byte(c_sof);
    push_byte(c_ver);
    push_byte(8'h07);
    settle();
    write_reg(fpp_pkg::CFG_START_BYTE, 16'h005A);
    write_reg(fpp_pkg::CFG_VERSION, 16'h0080);
    write_reg(fpp_pkg::CFG_CRC_INIT, 16'h0000);
    write_reg(CFG_UNUSED, 16'hFFFF);
    push_byte(8'h34);
    push_byte(8'h12);
    push_byte(8'h02);
    push_byte(8'h00);
    push_byte(8'($urandom_range(0, 255)));
    push_byte(8'($urandom_range(0, 255)));
    push_byte(p_crc[7:0]);
    push_byte(p_crc[15:8]);
    send_frame(8'h00, 16'h0000, 16'h0000, 1'b0);

    settle();
    write_reg(fpp_pkg::CFG_START_BYTE, 16'(fpp_pkg::START_BYTE_RST));
    write_reg(fpp_pkg::CFG_VERSION, 16'(fpp_pkg::VERSION_RST));
    write_reg(fpp_pkg::CFG_CRC_INIT, fpp_pkg::CRC_INIT_RST);
    run_phase(PHASE_ITEMS, 1'b1);

    settle();
    calm = 1'b1;
    write_reg(fpp_pkg::CFG_START_BYTE, 16'h0000);
    write_reg(fpp_pkg::CFG_VERSION, 16'h00FF);
    write_reg(fpp_pkg::CFG_CRC_INIT, 16'h0000);
    run_phase(PHASE_ITEMS, 1'b0);

    settle();
    calm = 1'b0;
    write_reg(fpp_pkg::CFG_START_BYTE, 16'h00FF);
    write_reg(fpp_pkg::CFG_VERSION, 16'h0000);
    write_reg(fpp_pkg::CFG_CRC_INIT, 16'hFFFF);
    run_phase(PHASE_ITEMS, 1'b1);

    settle();
    write_reg(fpp_pkg::CFG_START_BYTE, 16'($urandom_range(0, 255)));
    write_reg(fpp_pkg::CFG_VERSION, 16'($urandom_range(0, 255)));
    write_reg(fpp_pkg::CFG_CRC_INIT, 16'($urandom_range(0, 65535)));
    run_phase(PHASE_ITEMS, 1'b0);

    settle();
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/fpp_pkg.sv
rtl/framed_packet_parser_crc16.sv
rtl/fpp_checker.sv
bench/framed_packet_parser_crc16_tb.sv
